// File: design/htb_pkg.sv
// Package with shared types and constants of the Huffman tree builder.
package htb_pkg;

	localparam int SYMBOLS = 256;
	localparam int COUNT_BITS = 32;
	localparam int SYM_BITS = 8;
	localparam int IDX_BITS = 8;
	localparam int CNT_BITS = 9;
	localparam int NODE_BITS = 9;
	localparam int WGT_BITS = 40;
	localparam int WORK_BITS = NODE_BITS + WGT_BITS;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_MERGE = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_GATHER_RD,
		ST_GATHER_WT,
		ST_GATHER_WR,
		ST_SORT_RDI,
		ST_SORT_RDJ,
		ST_SORT_WT,
		ST_SORT_CMP,
		ST_SORT_WRJ,
		ST_SCAN_RD,
		ST_SCAN_WT,
		ST_SCAN_CMP,
		ST_LAST_RD,
		ST_LAST_WT,
		ST_WR_M1,
		ST_WR_M2,
		ST_DONE_RD,
		ST_DONE_WT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 merged;
		logic [NODE_BITS-1:0] left_node;
		logic [NODE_BITS-1:0] right_node;
		logic [NODE_BITS-1:0] new_node;
		logic [WGT_BITS-1:0]  weight;
		logic                 done_res;
		logic                 empty_res;
		logic [NODE_BITS-1:0] root_node;
	} result_t;

endpackage

// File: design/htb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module htb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: design/huffman_tree_builder.sv
// Top level of the Huffman tree builder: sequencer around one compare unit.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: symbol[7:0], count[39:8]; tuser: req_type
// m_axis    out  m_axis_tvalid/tready   tdata: result fields (see port comment)
// cfg       in   cfg_valid/cfg_ready    cfg_data: presort_enable
//
// A load or unknown request goes through ST_OUT; a clear sweeps the whole count RAM.
// A merge scans the n working nodes, and one with at most one node left reports done.
// The first merge adds a gather pass over all 256 symbols and, when presorting, an
// exchange sort of the gathered nodes.
// The work RAM has a single read port. After reset the count RAM is
// cleared by a pass over all 256 entries before the first item is taken.
// The input is not ready while an item is being worked or its result waits.
module huffman_tree_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // symbol[7:0], count[39:8]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// merged[0], left_node[9:1], right_node[18:10], new_node[27:19], weight[67:28],
	// done_res[68], empty_res[69], root_node[78:70], zero fill[79]
	output logic [79:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int IB = htb_pkg::IDX_BITS;
	localparam int NB = htb_pkg::NODE_BITS;
	localparam int WB = htb_pkg::WGT_BITS;
	localparam int CB = htb_pkg::COUNT_BITS;

	htb_pkg::state_t state_q, state_d;
	logic presort_q;
	logic building_q, building_d;
	logic [htb_pkg::CNT_BITS-1:0] act_q, act_d;
	logic [NB-1:0] nid_q, nid_d;
	logic [htb_pkg::CNT_BITS-1:0] i_q, i_d, j_q, j_d;
	logic [IB-1:0] m1_q, m1_d, m2_q, m2_d;
	logic [WB-1:0] w1_q, w1_d, w2_q, w2_d;
	logic [NB-1:0] id1_q, id1_d, id2_q, id2_d;
	logic [htb_pkg::WORK_BITS-1:0] hold_q, hold_d;
	htb_pkg::result_t res_q, res_d;
	logic oval_q, oval_d;

	logic          c_we;
	logic [IB-1:0] c_waddr, c_raddr;
	logic [CB-1:0] c_wdata, c_rdata;
	logic          w_we;
	logic [IB-1:0] w_waddr, w_raddr;
	logic [htb_pkg::WORK_BITS-1:0] w_wdata, w_rdata;
	logic [WB-1:0] rd_w;
	logic [NB-1:0] rd_id;

	htb_ram #(.WIDTH(CB), .DEPTH(htb_pkg::SYMBOLS)) u_count (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata));

	htb_ram #(.WIDTH(htb_pkg::WORK_BITS), .DEPTH(htb_pkg::SYMBOLS)) u_work (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata));

	assign rd_w  = w_rdata[WB-1:0];
	assign rd_id = w_rdata[htb_pkg::WORK_BITS-1:WB];

	assign s_axis_tready = (state_q == htb_pkg::ST_IDLE) && !oval_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = oval_q;
	assign m_axis_tdata  = {1'b0, res_q.root_node, res_q.empty_res, res_q.done_res,
		res_q.weight, res_q.new_node, res_q.right_node, res_q.left_node, res_q.merged};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= htb_pkg::ST_CLR;
			presort_q  <= 1'b0;
			building_q <= 1'b0;
			act_q      <= '0;
			nid_q      <= NB'(256);
			i_q        <= '0;
			oval_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			building_q <= building_d;
			act_q      <= act_d;
			nid_q      <= nid_d;
			i_q        <= i_d;
			oval_q     <= oval_d;
			if (cfg_valid && cfg_ready)
				presort_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		j_q <= j_d; m1_q <= m1_d; m2_q <= m2_d;
		w1_q <= w1_d; w2_q <= w2_d; id1_q <= id1_d; id2_q <= id2_d;
		hold_q <= hold_d; res_q <= res_d;
	end

	always_comb begin
		state_d = state_q; building_d = building_q; act_d = act_q; nid_d = nid_q;
		i_d = i_q; j_d = j_q; m1_d = m1_q; m2_d = m2_q;
		w1_d = w1_q; w2_d = w2_q; id1_d = id1_q; id2_d = id2_q; hold_d = hold_q;
		res_d = res_q; oval_d = oval_q;
		c_we = 1'b0; c_waddr = i_q[IB-1:0]; c_wdata = '0; c_raddr = i_q[IB-1:0];
		w_we = 1'b0; w_waddr = i_q[IB-1:0]; w_wdata = '0; w_raddr = i_q[IB-1:0];
		if (oval_q && m_axis_tready)
			oval_d = 1'b0;
		unique case (state_q)
			htb_pkg::ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					res_d = '0;
					i_d   = '0;
					unique case (htb_pkg::req_t'(s_axis_tuser))
						htb_pkg::REQ_LOAD: begin
							if (!building_q) begin
								c_we    = 1'b1;
								c_waddr = s_axis_tdata[7:0];
								c_wdata = s_axis_tdata[39:8];
							end
							state_d = htb_pkg::ST_OUT;
						end
						htb_pkg::REQ_CLEAR: begin
							building_d = 1'b0;
							act_d      = '0;
							nid_d      = NB'(256);
							state_d    = htb_pkg::ST_CLR;
							oval_d     = 1'b1;
						end
						htb_pkg::REQ_MERGE: begin
							if (!building_q) begin
								act_d   = '0;
								nid_d   = NB'(256);
								state_d = htb_pkg::ST_GATHER_RD;
							end else begin
								state_d = htb_pkg::ST_SCAN_RD;
							end
							building_d = 1'b1;
						end
						default: state_d = htb_pkg::ST_OUT;
					endcase
				end
			end
			htb_pkg::ST_OUT: begin
				oval_d  = 1'b1;
				state_d = htb_pkg::ST_IDLE;
			end
			htb_pkg::ST_CLR: begin
				c_we    = 1'b1;
				c_waddr = i_q[IB-1:0];
				i_d     = i_q + 1'b1;
				if (i_q[IB-1:0] == IB'(htb_pkg::SYMBOLS - 1)) begin
					i_d     = '0;
					state_d = htb_pkg::ST_IDLE;
				end
			end
			htb_pkg::ST_GATHER_RD: begin
				c_raddr = i_q[IB-1:0];
				state_d = htb_pkg::ST_GATHER_WT;
			end
			htb_pkg::ST_GATHER_WT: state_d = htb_pkg::ST_GATHER_WR;
			htb_pkg::ST_GATHER_WR: begin
				if (c_rdata != '0) begin
					w_we    = 1'b1;
					w_waddr = act_q[IB-1:0];
					w_wdata = {NB'(i_q), WB'(c_rdata)};
					act_d   = act_q + 1'b1;
				end
				i_d     = i_q + 1'b1;
				state_d = htb_pkg::ST_GATHER_RD;
				if (i_q[IB-1:0] == IB'(htb_pkg::SYMBOLS - 1)) begin
					i_d     = '0;
					state_d = presort_q ? htb_pkg::ST_SORT_RDI : htb_pkg::ST_SCAN_RD;
				end
			end
			// Exchange sort: hold_q keeps entry i, each j compared and swapped.
			htb_pkg::ST_SORT_RDI: begin
				if (i_q >= act_q) begin
					i_d     = '0;
					state_d = htb_pkg::ST_SCAN_RD;
				end else begin
					w_raddr = i_q[IB-1:0];
					j_d     = i_q + 1'b1;
					state_d = htb_pkg::ST_SORT_RDJ;
				end
			end
			htb_pkg::ST_SORT_RDJ: begin
				hold_d = w_rdata;
				if (j_q >= act_q) begin
					w_we    = 1'b1;
					w_waddr = i_q[IB-1:0];
					w_wdata = (j_q == i_q + 1'b1) ? w_rdata : hold_q;
					i_d     = i_q + 1'b1;
					state_d = htb_pkg::ST_SORT_RDI;
				end else begin
					w_raddr = j_q[IB-1:0];
					state_d = htb_pkg::ST_SORT_WT;
				end
			end
			htb_pkg::ST_SORT_WT: begin
				w_raddr = j_q[IB-1:0];
				state_d = htb_pkg::ST_SORT_CMP;
			end
			htb_pkg::ST_SORT_CMP: begin
				if (rd_w < hold_q[WB-1:0]) begin
					w_we    = 1'b1;
					w_waddr = j_q[IB-1:0];
					w_wdata = hold_q;
					hold_d  = w_rdata;
				end
				j_d     = j_q + 1'b1;
				state_d = htb_pkg::ST_SORT_WRJ;
			end
			htb_pkg::ST_SORT_WRJ: begin
				if (j_q >= act_q) begin
					w_we    = 1'b1;
					w_waddr = i_q[IB-1:0];
					w_wdata = hold_q;
					i_d     = i_q + 1'b1;
					state_d = htb_pkg::ST_SORT_RDI;
				end else begin
					w_raddr = j_q[IB-1:0];
					state_d = htb_pkg::ST_SORT_WT;
				end
			end
			// Merge scan: each entry passes ST_SCAN_RD, ST_SCAN_WT and ST_SCAN_CMP through the compare.
			htb_pkg::ST_SCAN_RD: begin
				if (act_q <= 9'd1) begin
					w_raddr = '0;
					state_d = htb_pkg::ST_DONE_RD;
				end else begin
					w_raddr = i_q[IB-1:0];
					state_d = htb_pkg::ST_SCAN_WT;
				end
			end
			htb_pkg::ST_SCAN_WT: state_d = htb_pkg::ST_SCAN_CMP;
			htb_pkg::ST_SCAN_CMP: begin
				if (i_q == '0) begin
					m1_d = '0; w1_d = rd_w; id1_d = rd_id;
				end else if (i_q == 9'd1) begin
					if (w1_q > rd_w) begin
						m2_d = m1_q; w2_d = w1_q; id2_d = id1_q;
						m1_d = 8'd1; w1_d = rd_w; id1_d = rd_id;
					end else begin
						m2_d = 8'd1; w2_d = rd_w; id2_d = rd_id;
					end
				end else if (rd_w < w1_q) begin
					m2_d = m1_q; w2_d = w1_q; id2_d = id1_q;
					m1_d = i_q[IB-1:0]; w1_d = rd_w; id1_d = rd_id;
				end else if (rd_w < w2_q) begin
					m2_d = i_q[IB-1:0]; w2_d = rd_w; id2_d = rd_id;
				end
				i_d     = i_q + 1'b1;
				state_d = htb_pkg::ST_SCAN_RD;
				if (i_q + 1'b1 >= act_q) begin
					i_d     = '0;
					state_d = htb_pkg::ST_LAST_RD;
				end
				if (act_q <= 9'd1)
					state_d = htb_pkg::ST_DONE_RD;
			end
			htb_pkg::ST_LAST_RD: begin
				w_raddr = IB'(act_q - 1'b1);
				state_d = htb_pkg::ST_LAST_WT;
			end
			htb_pkg::ST_LAST_WT: begin
				w_raddr = IB'(act_q - 1'b1);
				state_d = htb_pkg::ST_WR_M1;
			end
			htb_pkg::ST_WR_M1: begin
				hold_d  = w_rdata;
				w_we    = 1'b1;
				w_waddr = m1_q;
				w_wdata = {nid_q, w1_q + w2_q};
				// The last entry may be the first minimum, which was just overwritten.
				if (IB'(act_q - 1'b1) == m1_q)
					hold_d = {nid_q, w1_q + w2_q};
				res_d.merged     = 1'b1;
				res_d.left_node  = id1_q;
				res_d.right_node = id2_q;
				res_d.new_node   = nid_q;
				res_d.weight     = w1_q + w2_q;
				state_d = htb_pkg::ST_WR_M2;
			end
			htb_pkg::ST_WR_M2: begin
				w_we    = 1'b1;
				w_waddr = m2_q;
				w_wdata = hold_q;
				act_d   = act_q - 1'b1;
				nid_d   = nid_q + 1'b1;
				state_d = htb_pkg::ST_OUT;
			end
			htb_pkg::ST_DONE_RD: state_d = htb_pkg::ST_DONE_WT;
			htb_pkg::ST_DONE_WT: begin
				res_d.done_res  = 1'b1;
				res_d.empty_res = (act_q == '0);
				res_d.root_node = (act_q == '0) ? '0 : rd_id;
				state_d = htb_pkg::ST_OUT;
			end
			default: state_d = htb_pkg::ST_IDLE;
		endcase
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while a result waits");
	a_merge_xor_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[68]))
		else $error("result both merged and done");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

endmodule

// File: verif/huffman_tree_builder_tb.sv
// Self-checking testbench for the Huffman tree builder: directed and random histograms.
module huffman_tree_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // symbol[7:0], count[39:8]
	logic [1:0]  s_axis_tuser;  // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// merged[0], left_node[9:1], right_node[18:10], new_node[27:19], weight[67:28],
	// done_res[68], empty_res[69], root_node[78:70], zero fill[79]
	logic [79:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	huffman_tree_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Mirror of the block's histogram and working list.
	logic [htb_pkg::COUNT_BITS-1:0] hist[htb_pkg::SYMBOLS];
	logic [htb_pkg::NODE_BITS-1:0]  list_id[htb_pkg::SYMBOLS];
	logic [htb_pkg::WGT_BITS-1:0]   list_wt[htb_pkg::SYMBOLS];
	int                             list_len;
	logic [htb_pkg::NODE_BITS-1:0]  next_id;
	bit                             in_build;
	bit                             presort;

	htb_pkg::result_t merge_records[$];
	int      errors;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic predict_request(input htb_pkg::req_t req, input logic [7:0] sym,
			input logic [31:0] cnt, output htb_pkg::result_t res);
		int m1;
		int m2;
		int last;
		logic [htb_pkg::WGT_BITS-1:0] tw;
		logic [htb_pkg::NODE_BITS-1:0] tn;
		logic [htb_pkg::WGT_BITS-1:0] sum;
		res = '0;
		case (req)
			htb_pkg::REQ_LOAD: begin
				if (!in_build)
					hist[sym] = cnt;
			end
			htb_pkg::REQ_CLEAR: begin
				foreach (hist[k])
					hist[k] = '0;
				list_len = 0;
				next_id = 9'd256;
				in_build = 1'b0;
			end
			htb_pkg::REQ_MERGE: begin
				if (!in_build) begin
					list_len = 0;
					for (int s = 0; s < htb_pkg::SYMBOLS; s++) begin
						if (hist[s] != 0) begin
							list_id[list_len] = s[htb_pkg::NODE_BITS-1:0];
							list_wt[list_len] = {8'd0, hist[s]};
							list_len++;
						end
					end
					if (presort) begin
						for (int i = 0; i < list_len; i++) begin
							for (int j = i + 1; j < list_len; j++) begin
								if (list_wt[j] < list_wt[i]) begin
									tw = list_wt[i];
									tn = list_id[i];
									list_wt[i] = list_wt[j];
									list_id[i] = list_id[j];
									list_wt[j] = tw;
									list_id[j] = tn;
								end
							end
						end
					end
					next_id = 9'd256;
					in_build = 1'b1;
				end
				if (list_len <= 1) begin
					res.done_res = 1'b1;
					if (list_len == 0)
						res.empty_res = 1'b1;
					else
						res.root_node = list_id[0];
				end else begin
					m1 = 0;
					m2 = 1;
					if (list_wt[0] > list_wt[1]) begin
						m1 = 1;
						m2 = 0;
					end
					for (int i = 2; i < list_len; i++) begin
						if (list_wt[i] < list_wt[m1]) begin
							m2 = m1;
							m1 = i;
						end else if (list_wt[i] < list_wt[m2]) begin
							m2 = i;
						end
					end
					sum = list_wt[m1] + list_wt[m2];
					res.merged = 1'b1;
					res.left_node = list_id[m1];
					res.right_node = list_id[m2];
					res.new_node = next_id;
					res.weight = sum;
					// The new node goes in first, so a last entry that was a
					// minimum may overwrite it with itself.
					list_id[m1] = next_id;
					list_wt[m1] = sum;
					last = list_len - 1;
					list_id[m2] = list_id[last];
					list_wt[m2] = list_wt[last];
					list_len--;
					next_id = next_id + 9'd1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [39:0] exp_v,
			input logic [39:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Output side: random ready, long holds on request, one check per beat.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (merge_records.size() == 0) begin
					$display("%0t: unexpected result beat %0h", $time, m_axis_tdata);
					errors++;
				end else begin
					htb_pkg::result_t e;
					e = merge_records.pop_front();
					check_field("merged", 40'(e.merged), 40'(m_axis_tdata[0]));
					check_field("left_node", 40'(e.left_node), 40'(m_axis_tdata[9:1]));
					check_field("right_node", 40'(e.right_node), 40'(m_axis_tdata[18:10]));
					check_field("new_node", 40'(e.new_node), 40'(m_axis_tdata[27:19]));
					check_field("weight", e.weight, m_axis_tdata[67:28]);
					check_field("done_res", 40'(e.done_res), 40'(m_axis_tdata[68]));
					check_field("empty_res", 40'(e.empty_res), 40'(m_axis_tdata[69]));
					check_field("root_node", 40'(e.root_node), 40'(m_axis_tdata[78:70]));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Leaves tvalid high on return so back-to-back beats need no re-raise.
	task automatic send_request(input htb_pkg::req_t req, input logic [7:0] sym = '0,
			input logic [31:0] cnt = '0);
		htb_pkg::result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 40'({$urandom, $urandom});
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {cnt, sym};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_request(req, sym, cnt, res);
		merge_records.push_back(res);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (merge_records.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_presort(input bit value);
		drain();
		repeat (10) @(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		presort = value;
	endtask

	task automatic merge_until_done(input int extra);
		while (list_len > 1 || !in_build)
			send_request(htb_pkg::REQ_MERGE);
		repeat (extra)
			send_request(htb_pkg::REQ_MERGE);
	endtask

	task automatic test_directed;
		send_request(htb_pkg::REQ_MERGE);                   // empty histogram
		send_request(htb_pkg::REQ_CLEAR);
		send_request(htb_pkg::REQ_LOAD, 8'd0, 32'hFFFF_FFFF);
		send_request(htb_pkg::REQ_LOAD, 8'd255, 32'hFFFF_FFFF);
		send_request(htb_pkg::REQ_MERGE);
		send_request(htb_pkg::REQ_MERGE);                   // done with root
		send_request(htb_pkg::REQ_LOAD, 8'd7, 32'd5);       // ignored during build
		send_request(htb_pkg::REQ_MERGE);                   // done again
		send_request(htb_pkg::REQ_NONE, 8'hAA, 32'h5555_5555);
		send_request(htb_pkg::REQ_CLEAR);
		send_request(htb_pkg::REQ_LOAD, 8'd200, 32'd1);     // single leaf
		send_request(htb_pkg::REQ_MERGE);
		send_request(htb_pkg::REQ_CLEAR);
		// Equal weights exercise tie breaking.
		send_request(htb_pkg::REQ_LOAD, 8'd9, 32'd3);
		send_request(htb_pkg::REQ_LOAD, 8'd4, 32'd3);
		send_request(htb_pkg::REQ_LOAD, 8'd130, 32'd3);
		send_request(htb_pkg::REQ_LOAD, 8'd4, 32'd0);       // zero count drops the leaf
		send_request(htb_pkg::REQ_LOAD, 8'd60, 32'd1);
		merge_until_done(1);
		send_request(htb_pkg::REQ_CLEAR);
	endtask

	task automatic test_full_histogram;
		write_presort(1'b1);
		send_request(htb_pkg::REQ_CLEAR);
		for (int s = 0; s < htb_pkg::SYMBOLS; s++)
			send_request(htb_pkg::REQ_LOAD, s[7:0], (s % 5 == 0) ? 32'hFFFF_FFFF :
				(s % 3 == 0) ? $urandom_range(1, 3) : $urandom);
		merge_until_done(0);
		write_presort(1'b0);
	endtask

	task automatic random_build;
		int leaves;
		leaves = $urandom_range(0, 9);
		if ($urandom_range(3) == 0)
			write_presort(1'($urandom_range(1)));
		if ($urandom_range(7) != 0)
			send_request(htb_pkg::REQ_CLEAR);
		for (int i = 0; i < leaves; i++) begin
			case ($urandom_range(9))
				0: send_request(htb_pkg::REQ_NONE, 8'($urandom), $urandom);
				1: send_request(htb_pkg::REQ_LOAD, 8'($urandom), 32'd0);
				2, 3, 4: send_request(htb_pkg::REQ_LOAD, 8'($urandom), $urandom_range(1, 4));
				default: send_request(htb_pkg::REQ_LOAD, 8'($urandom), $urandom);
			endcase
		end
		while (list_len > 1 || !in_build) begin
			if ($urandom_range(11) == 0)
				send_request(htb_pkg::REQ_LOAD, 8'($urandom), $urandom);
			send_request(htb_pkg::REQ_MERGE);
		end
		if ($urandom_range(1))
			send_request(htb_pkg::REQ_MERGE);
	endtask

	task automatic test_random;
		send_idle_pct = 14;
		recv_idle_pct = 72;
		repeat (6) random_build();
		// Output stalls while input keeps coming, so the block backs up.
		hold_left = 600;
		repeat (4) random_build();
		send_idle_pct = 72;
		recv_idle_pct = 14;
		repeat (10) random_build();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) random_build();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = htb_pkg::REQ_LOAD;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		errors = 0;
		hold_left = 0;
		send_idle_pct = 14;
		recv_idle_pct = 72;
		foreach (hist[k])
			hist[k] = '0;
		list_len = 0;
		next_id = 9'd256;
		in_build = 1'b0;
		presort = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_histogram();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
